### sv/source_priority_failover_arbiter_assert.svh
// Assertion macros for the source priority failover arbiter.
`ifndef SOURCE_PRIORITY_FAILOVER_ARBITER_ASSERT_SVH
`define SOURCE_PRIORITY_FAILOVER_ARBITER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SPFA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
// next-cycle implication
`define SPFA_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define SPFA_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define SPFA_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

### sv/spfa_pkg.sv
// Types and constants shared by the source priority failover arbiter.
package spfa_pkg;

   localparam int PRI_BITS  = 8;
   localparam int MASK_BITS = 5;

   localparam logic [7:0] WD_RESET   = 8'd5;
   localparam logic [7:0] PRI_MAX    = 8'd255;
   localparam logic [2:0] SAT_CAT    = 3'd4;
   localparam logic [7:0] GPS_TO_RST = 8'd5;
   localparam logic [7:0] SAT_TO_RST = 8'd5;
   localparam logic [4:0] FMASK_RST  = 5'd1;

   localparam logic CMD_OFFER = 1'b0;
   localparam logic CMD_TICK  = 1'b1;

   localparam logic [1:0] CSR_GPS_TIMEOUT   = 2'd0;
   localparam logic [1:0] CSR_SAT_TIMEOUT   = 2'd1;
   localparam logic [1:0] CSR_FAILOVER_MASK = 2'd2;

   typedef enum logic [2:0] {
      STAT_DROP_LOW     = 3'd0,
      STAT_RESTORED     = 3'd1,
      STAT_DEMOTE_SRC   = 3'd2,
      STAT_DEMOTE_IDENT = 3'd3,
      STAT_ACCEPT       = 3'd4,
      STAT_TABLE_FULL   = 3'd5,
      STAT_TICK         = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } back_state_type;

   typedef struct packed {
      logic        cmd;
      logic [2:0]  category;
      logic [15:0] key_id;
      logic [15:0] source_id;
      logic [15:0] ident_id;
      logic        ident_present;
   } req_type;

   typedef struct packed {
      logic        accepted;
      status_type  status;
      logic [7:0]  key_priority;
      logic [7:0]  active_level;
      logic [4:0]  expired_mask;
      logic [4:0]  newly_expired_mask;
   } rsp_type;

   typedef struct packed {
      req_type req;
      logic    is_tick;
      logic    cat_ok;
   } job_type;

   typedef struct packed {
      logic [7:0] gps_timeout;
      logic [7:0] sat_timeout;
      logic [4:0] failover_mask;
   } cfg_type;

   typedef struct packed {
      logic [1:0] count;
   } front_stat_type;

   typedef struct packed {
      logic busy;
   } back_stat_type;

endpackage

### sv/source_priority_failover_arbiter.sv
// Source priority failover arbiter: register file, front queue and table-scanning back end.
// A message beat is compared against its category's key table, one entry a cycle through the
// single read port of the table RAM; a tick or a bad category skips the scan.
// The back end holds while a result is unread, and two beats queue in front.
// Synchronous active-high reset clears valid bits, levels, sources and loads watchdogs with 5.
module source_priority_failover_arbiter #(
   parameter int TABLE_ENTRIES = 16,
   parameter int CATEGORIES    = 5,
   parameter int ID_BITS       = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  spfa_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output spfa_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [7:0]        csr_wdata
);
   import spfa_pkg::*;

   `include "source_priority_failover_arbiter_assert.svh"

   cfg_type        cfg_ff, cfg_in;
   logic           job_valid, job_pop;
   job_type        job_data;
   front_stat_type front_stat;
   back_stat_type  back_stat;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_GPS_TIMEOUT:   cfg_in.gps_timeout   = csr_wdata;
            CSR_SAT_TIMEOUT:   cfg_in.sat_timeout   = csr_wdata;
            CSR_FAILOVER_MASK: cfg_in.failover_mask = csr_wdata[4:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gps_timeout   <= GPS_TO_RST;
         cfg_ff.sat_timeout   <= SAT_TO_RST;
         cfg_ff.failover_mask <= FMASK_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   spfa_front #(.CATEGORIES(CATEGORIES)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .job_valid (job_valid),
      .job_data  (job_data),
      .job_pop   (job_pop),
      .stat      (front_stat)
   );

   spfa_back #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .CATEGORIES    (CATEGORIES),
      .ID_BITS       (ID_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job_valid (job_valid),
      .job_data  (job_data),
      .job_pop   (job_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .stat      (back_stat)
   );

   // the back end only works while the result register is free
   `SPFA_ASSERT_IMP(a_busy_out_free, clock, reset, back_stat.busy, rsp_empty)
   `SPFA_ASSERT_NXT(a_push_queued, clock, reset, req_push && !req_full, front_stat.count != 2'd0)
   `SPFA_ASSERT_IMP(a_tick_not_acc, clock, reset, !rsp_empty && rsp_data.status == STAT_TICK, !rsp_data.accepted)

endmodule

### sv/spfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module spfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

### sv/spfa_front.sv
// Front end: accepts request beats, classifies them and queues them for the back end.
module spfa_front #(
   parameter int CATEGORIES = 5
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   output logic                    req_full,
   input  spfa_pkg::req_type       req_data,
   output logic                    job_valid,
   output spfa_pkg::job_type       job_data,
   input  logic                    job_pop,
   output spfa_pkg::front_stat_type stat
);
   import spfa_pkg::*;

   job_type    buf_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   job_type    job_new;
   logic       do_push, do_pop;

   always_comb begin
      job_new.req     = req_data;
      job_new.is_tick = (req_data.cmd == CMD_TICK);
      job_new.cat_ok  = ({1'b0, req_data.category} < 4'(CATEGORIES));
   end

   assign req_full  = (count_ff == 2'd2);
   assign job_valid = (count_ff != 2'd0);
   assign job_data  = buf_ff[rd_ptr_ff];
   assign do_push   = req_push && !req_full;
   assign do_pop    = job_pop && job_valid;
   assign stat.count = count_ff;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         buf_ff[wr_ptr_ff] <= job_new;
      end
   end

endmodule

### sv/spfa_back.sv
// Back end: scans the key table, updates arbitration state and watchdogs, holds the result.
module spfa_back #(
   parameter int TABLE_ENTRIES = 16,
   parameter int CATEGORIES    = 5,
   parameter int ID_BITS       = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  spfa_pkg::cfg_type       cfg,
   input  logic                    job_valid,
   input  spfa_pkg::job_type       job_data,
   output logic                    job_pop,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output spfa_pkg::rsp_type       rsp_data,
   output spfa_pkg::back_stat_type stat
);
   import spfa_pkg::*;

   localparam int TOTAL = CATEGORIES * TABLE_ENTRIES;
   localparam int AW    = $clog2(TOTAL);
   localparam int IW    = $clog2(TABLE_ENTRIES);
   localparam int CW    = (CATEGORIES > 1) ? $clog2(CATEGORIES) : 1;
   localparam int RW    = ID_BITS + PRI_BITS;

   back_state_type state_ff, state_in;
   job_type        job_ff, job_in;
   logic [IW:0]    rd_idx_ff, rd_idx_in;
   logic           pend_ff, pend_in;
   logic [IW-1:0]  cmp_idx_ff, cmp_idx_in;
   logic           found_ff, found_in;
   logic [IW-1:0]  slot_ff, slot_in;
   logic [7:0]     slot_pri_ff, slot_pri_in;
   logic           free_found_ff, free_found_in;
   logic [IW-1:0]  free_ff, free_in;
   logic [7:0]     top_ff, top_in;

   logic [TOTAL-1:0] valid_ff, valid_in;
   logic [CATEGORIES-1:0][7:0]         level_ff, level_in;
   logic [CATEGORIES-1:0][ID_BITS-1:0] src_ff, src_in;
   logic [CATEGORIES-1:0]              srcv_ff, srcv_in;
   logic [CATEGORIES-1:0][ID_BITS-1:0] idn_ff, idn_in;
   logic [CATEGORIES-1:0]              idnv_ff, idnv_in;
   logic [CATEGORIES-1:0][7:0]         wd_ff, wd_in;
   logic [CATEGORIES-1:0]              exp_ff, exp_in;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_ff, out_in;

   logic [CW-1:0]         cat_i;
   logic [AW-1:0]         base;
   logic [ID_BITS-1:0]    key_m, src_m, idn_m;
   logic [CATEGORIES-1:0] fmask;
   logic [CATEGORIES-1:0] newly;

   logic          ram_we, ram_re;
   logic [AW-1:0] ram_waddr, ram_raddr, cmp_addr;
   logic [RW-1:0] ram_wdata, ram_rdata;
   logic          ent_valid;
   logic [ID_BITS-1:0] ent_key;
   logic [7:0]    ent_pri;

   logic          have, ins, demote, accept;
   logic [IW-1:0] sl;
   logic [7:0]    p, lvl, dem, newp, reload_t;

   assign cat_i  = job_ff.req.category[CW-1:0];
   assign base   = AW'(job_ff.req.category * TABLE_ENTRIES);
   assign key_m  = ID_BITS'(job_ff.req.key_id);
   assign src_m  = ID_BITS'(job_ff.req.source_id);
   assign idn_m  = ID_BITS'(job_ff.req.ident_id);
   assign fmask  = CATEGORIES'(cfg.failover_mask);

   assign ram_raddr = base + AW'(rd_idx_ff[IW-1:0]);
   assign cmp_addr  = base + AW'(cmp_idx_ff);
   assign ent_valid = valid_ff[cmp_addr];
   assign ent_key   = ram_rdata[RW-1:PRI_BITS];
   assign ent_pri   = ram_rdata[PRI_BITS-1:0];

   spfa_ram #(.WIDTH(RW), .DEPTH(TOTAL)) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Decision terms for a message, from the finished scan
   always_comb begin
      have     = found_ff || free_found_ff;
      ins      = !found_ff && free_found_ff;
      sl       = found_ff ? slot_ff : free_ff;
      p        = found_ff ? slot_pri_ff : 8'd0;
      lvl      = level_ff[cat_i];
      dem      = (top_ff == PRI_MAX) ? PRI_MAX : top_ff + 8'd1;
      reload_t = (job_ff.req.category == SAT_CAT) ? cfg.sat_timeout : cfg.gps_timeout;
   end

   always_comb begin
      state_in      = state_ff;
      job_in        = job_ff;
      rd_idx_in     = rd_idx_ff;
      pend_in       = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      found_in      = found_ff;
      slot_in       = slot_ff;
      slot_pri_in   = slot_pri_ff;
      free_found_in = free_found_ff;
      free_in       = free_ff;
      top_in        = top_ff;
      valid_in      = valid_ff;
      level_in      = level_ff;
      src_in        = src_ff;
      srcv_in       = srcv_ff;
      idn_in        = idn_ff;
      idnv_in       = idnv_ff;
      wd_in         = wd_ff;
      exp_in        = exp_ff;
      out_valid_in  = out_valid_ff && !rsp_pop;
      out_in        = out_ff;
      newly         = '0;
      job_pop       = 1'b0;
      ram_re        = 1'b0;
      ram_we        = 1'b0;
      ram_waddr     = base + AW'(sl);
      demote        = 1'b0;
      accept        = 1'b0;
      newp          = p;
      ram_wdata     = {key_m, newp};

      case (state_ff)
         ST_IDLE: begin
            if (job_valid && !out_valid_ff) begin
               job_pop       = 1'b1;
               job_in        = job_data;
               rd_idx_in     = '0;
               found_in      = 1'b0;
               free_found_in = 1'b0;
               top_in        = 8'd0;
               state_in      = (job_data.is_tick || !job_data.cat_ok) ? ST_FINISH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            // issue one read per cycle, compare the entry read the cycle before
            if (rd_idx_ff < (IW+1)'(TABLE_ENTRIES)) begin
               ram_re     = 1'b1;
               rd_idx_in  = rd_idx_ff + (IW+1)'(1);
               pend_in    = 1'b1;
               cmp_idx_in = rd_idx_ff[IW-1:0];
            end
            if (pend_ff) begin
               if (ent_valid) begin
                  if (ent_key == key_m && !found_ff) begin
                     found_in    = 1'b1;
                     slot_in     = cmp_idx_ff;
                     slot_pri_in = ent_pri;
                  end
                  if (ent_pri > top_ff) begin
                     top_in = ent_pri;
                  end
               end else if (!free_found_ff) begin
                  free_found_in = 1'b1;
                  free_in       = cmp_idx_ff;
               end
               if (cmp_idx_ff == IW'(TABLE_ENTRIES - 1)) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            out_in.accepted     = 1'b0;
            out_in.status       = STAT_DROP_LOW;
            out_in.key_priority = 8'd0;
            out_in.active_level = 8'd0;
            if (job_ff.is_tick) begin
               for (int c = 0; c < CATEGORIES; c++) begin
                  if (wd_ff[c] != 8'd0) begin
                     wd_in[c] = wd_ff[c] - 8'd1;
                     if (wd_ff[c] == 8'd1) begin
                        exp_in[c] = 1'b1;
                        newly[c]  = 1'b1;
                     end
                  end else begin
                     exp_in[c] = 1'b1;
                  end
                  if (exp_in[c] && fmask[c]) begin
                     level_in[c] = (level_ff[c] == PRI_MAX) ? PRI_MAX : level_ff[c] + 8'd1;
                     srcv_in[c]  = 1'b0;
                     idnv_in[c]  = 1'b0;
                  end
               end
               out_in.status = STAT_TICK;
               if (job_ff.cat_ok) begin
                  out_in.active_level = level_in[cat_i];
               end
            end else if (job_ff.cat_ok) begin
               if (!have) begin
                  out_in.status = STAT_TABLE_FULL;
               end else begin
                  if (p > lvl) begin
                     out_in.status = STAT_DROP_LOW;
                  end else if (p < lvl) begin
                     level_in[cat_i] = p;
                     accept          = 1'b1;
                     out_in.status   = STAT_RESTORED;
                  end else if (srcv_ff[cat_i] && src_ff[cat_i] != src_m) begin
                     demote        = 1'b1;
                     out_in.status = STAT_DEMOTE_SRC;
                  end else if (job_ff.req.ident_present && idnv_ff[cat_i]
                               && idn_ff[cat_i] != idn_m) begin
                     demote        = 1'b1;
                     out_in.status = STAT_DEMOTE_IDENT;
                  end else begin
                     accept        = 1'b1;
                     out_in.status = STAT_ACCEPT;
                  end
                  if (demote) begin
                     newp = dem;
                  end
                  ram_wdata = {key_m, newp};
                  if (ins || demote) begin
                     ram_we = 1'b1;
                  end
                  if (ins) begin
                     valid_in[ram_waddr] = 1'b1;
                  end
                  if (accept) begin
                     src_in[cat_i]  = src_m;
                     srcv_in[cat_i] = 1'b1;
                     idn_in[cat_i]  = job_ff.req.ident_present ? idn_m : '0;
                     idnv_in[cat_i] = job_ff.req.ident_present;
                     wd_in[cat_i]   = reload_t;
                     exp_in[cat_i]  = (reload_t == 8'd0);
                  end
                  out_in.accepted     = accept;
                  out_in.key_priority = newp;
               end
               out_in.active_level = level_in[cat_i];
            end
            out_in.expired_mask       = MASK_BITS'(exp_in);
            out_in.newly_expired_mask = MASK_BITS'(newly);
            out_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         valid_ff     <= '0;
         level_ff     <= '0;
         src_ff       <= '0;
         srcv_ff      <= '0;
         idn_ff       <= '0;
         idnv_ff      <= '0;
         wd_ff        <= {CATEGORIES{WD_RESET}};
         exp_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
         valid_ff     <= valid_in;
         level_ff     <= level_in;
         src_ff       <= src_in;
         srcv_ff      <= srcv_in;
         idn_ff       <= idn_in;
         idnv_ff      <= idnv_in;
         wd_ff        <= wd_in;
         exp_ff       <= exp_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff        <= job_in;
      rd_idx_ff     <= rd_idx_in;
      cmp_idx_ff    <= cmp_idx_in;
      found_ff      <= found_in;
      slot_ff       <= slot_in;
      slot_pri_ff   <= slot_pri_in;
      free_found_ff <= free_found_in;
      free_ff       <= free_in;
      top_ff        <= top_in;
      out_ff        <= out_in;
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;
   assign stat.busy = (state_ff != ST_IDLE);

endmodule

### test/source_priority_failover_arbiter_checker.sv
// Checker for the source priority failover arbiter: tracks its state, predicts results, compares.
module source_priority_failover_arbiter_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  logic              req_full,
   input  spfa_pkg::req_type req_data,
   input  logic              rsp_empty,
   input  logic              rsp_pop,
   input  spfa_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [7:0]        csr_wdata,
   output int                fail_count,
   output int                outstanding
);
   import spfa_pkg::*;

   localparam int NCAT    = 5;
   localparam int NENTRY  = 16;

   logic [15:0] key_tab   [NCAT][NENTRY];
   logic [7:0]  pri_tab   [NCAT][NENTRY];
   logic        used_tab  [NCAT][NENTRY];
   logic [7:0]  level     [NCAT];
   logic [15:0] src_act   [NCAT];
   logic        src_ok    [NCAT];
   logic [15:0] idn_act   [NCAT];
   logic        idn_ok    [NCAT];
   logic [7:0]  dog       [NCAT];
   logic        dog_out   [NCAT];
   logic [7:0]  gps_reload;
   logic [7:0]  sat_reload;
   logic [4:0]  fo_mask;

   rsp_type expected_rsps[$];

   assign outstanding = expected_rsps.size();

   function automatic logic [4:0] expired_now();
      logic [4:0] m;
      m = '0;
      for (int c = 0; c < NCAT; c++) m[c] = dog_out[c];
      return m;
   endfunction

   function automatic logic [7:0] next_demote(int c);
      int top;
      top = -10;
      for (int i = 0; i < NENTRY; i++)
         if (used_tab[c][i] && int'(pri_tab[c][i]) > top) top = int'(pri_tab[c][i]);
      return (top >= 255) ? 8'd255 : 8'(top + 1);
   endfunction

   // advance the arbitration state by one beat and return its result
   function automatic rsp_type arbitrate(req_type r);
      rsp_type o;
      int c, slot, free_slot;
      logic [7:0] p;
      logic [7:0] t;
      o = '0;
      o.status = STAT_DROP_LOW;
      c = int'(r.category);
      if (r.cmd == CMD_TICK) begin
         for (int k = 0; k < NCAT; k++) begin
            if (dog[k] != 8'd0) begin
               dog[k] = dog[k] - 8'd1;
               if (dog[k] == 8'd0) begin
                  dog_out[k] = 1'b1;
                  o.newly_expired_mask[k] = 1'b1;
               end
            end else begin
               dog_out[k] = 1'b1;
            end
            if (dog_out[k] && fo_mask[k]) begin
               if (level[k] != 8'd255) level[k] = level[k] + 8'd1;
               src_ok[k] = 1'b0;
               idn_ok[k] = 1'b0;
            end
         end
         o.status = STAT_TICK;
      end else if (c < NCAT) begin
         slot = NENTRY;
         free_slot = NENTRY;
         for (int i = 0; i < NENTRY; i++) begin
            if (used_tab[c][i]) begin
               if (key_tab[c][i] == r.key_id && slot == NENTRY) slot = i;
            end else if (free_slot == NENTRY) begin
               free_slot = i;
            end
         end
         if (slot == NENTRY && free_slot < NENTRY) begin
            slot = free_slot;
            used_tab[c][slot] = 1'b1;
            key_tab[c][slot] = r.key_id;
            pri_tab[c][slot] = 8'd0;
         end
         if (slot == NENTRY) begin
            o.status = STAT_TABLE_FULL;
         end else begin
            p = pri_tab[c][slot];
            if (p > level[c]) begin
               o.status = STAT_DROP_LOW;
            end else if (p < level[c] || !((src_ok[c] && src_act[c] != r.source_id) ||
                         (r.ident_present && idn_ok[c] && idn_act[c] != r.ident_id))) begin
               o.status = (p < level[c]) ? STAT_RESTORED : STAT_ACCEPT;
               level[c] = p;
               src_act[c] = r.source_id;
               src_ok[c] = 1'b1;
               idn_act[c] = r.ident_present ? r.ident_id : 16'd0;
               idn_ok[c] = r.ident_present;
               o.accepted = 1'b1;
               t = (c == int'(SAT_CAT)) ? sat_reload : gps_reload;
               dog[c] = t;
               dog_out[c] = (t == 8'd0);
            end else begin
               o.status = (src_ok[c] && src_act[c] != r.source_id) ?
                          STAT_DEMOTE_SRC : STAT_DEMOTE_IDENT;
               pri_tab[c][slot] = next_demote(c);
            end
            o.key_priority = pri_tab[c][slot];
         end
      end
      o.active_level = (c < NCAT) ? level[c] : 8'd0;
      o.expired_mask = expired_now();
      return o;
   endfunction

   task automatic report(string field, logic [7:0] want, logic [7:0] got);
      $display("%0t: mismatch in %s: expected %0d, actual %0d", $time, field, want, got);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int c = 0; c < NCAT; c++) begin
            for (int i = 0; i < NENTRY; i++) used_tab[c][i] = 1'b0;
            level[c] = 8'd0;
            src_act[c] = 16'd0;
            src_ok[c] = 1'b0;
            idn_act[c] = 16'd0;
            idn_ok[c] = 1'b0;
            dog[c] = WD_RESET;
            dog_out[c] = 1'b0;
         end
         gps_reload = GPS_TO_RST;
         sat_reload = SAT_TO_RST;
         fo_mask = FMASK_RST;
         expected_rsps.delete();
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_GPS_TIMEOUT:   gps_reload = csr_wdata;
               CSR_SAT_TIMEOUT:   sat_reload = csr_wdata;
               CSR_FAILOVER_MASK: fo_mask = csr_wdata[4:0];
               default: ;
            endcase
         end
         if (rsp_pop && !rsp_empty) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected result beat, actual %p", $time, rsp_data);
               fail_count++;
            end else begin
               want = expected_rsps.pop_front();
               if (want !== rsp_data) begin
                  fail_count++;
                  if (want.accepted !== rsp_data.accepted)
                     report("accepted", want.accepted, rsp_data.accepted);
                  if (want.status !== rsp_data.status)
                     report("status", want.status, rsp_data.status);
                  if (want.key_priority !== rsp_data.key_priority)
                     report("key_priority", want.key_priority, rsp_data.key_priority);
                  if (want.active_level !== rsp_data.active_level)
                     report("active_level", want.active_level, rsp_data.active_level);
                  if (want.expired_mask !== rsp_data.expired_mask)
                     report("expired_mask", want.expired_mask, rsp_data.expired_mask);
                  if (want.newly_expired_mask !== rsp_data.newly_expired_mask)
                     report("newly_expired_mask", want.newly_expired_mask,
                            rsp_data.newly_expired_mask);
               end
            end
         end
         if (req_push && !req_full) expected_rsps.push_back(arbitrate(req_data));
      end
   end

endmodule

### test/tb_source_priority_failover_arbiter.sv
// Testbench top for the source priority failover arbiter: stimulus, idling and verdict.
module tb_source_priority_failover_arbiter;
   import spfa_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic       req_full;
   req_type    req_data = '0;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_index = '0;
   logic [7:0] csr_wdata = '0;
   int         fail_count;
   int         outstanding;
   int         cycle_count = 0;
   int         pop_stall = 0;
   bit         calm = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   source_priority_failover_arbiter DUT (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   source_priority_failover_arbiter_checker checker_inst (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .outstanding(outstanding)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("source_priority_failover_arbiter test failed");
         $finish;
      end
   end

   // receiver: stall in random bursts
   always @(posedge clock) begin
      if (pop_stall > 0) begin
         pop_stall <= pop_stall - 1;
         rsp_pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
         pop_stall <= $urandom_range(0, 7);
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   task automatic push_beat(req_type r);
      req_data <= r;
      req_push <= 1'b1;
      do @(posedge clock); while (req_full);
   endtask

   task automatic maybe_gap();
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_push <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (25) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [7:0] val);
      csr_index <= idx;
      csr_wdata <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic req_type offer(logic [2:0] cat, logic [15:0] key, logic [15:0] src,
                                     logic [15:0] idn, logic idp);
      req_type r;
      r.cmd = CMD_OFFER;
      r.category = cat;
      r.key_id = key;
      r.source_id = src;
      r.ident_id = idn;
      r.ident_present = idp;
      return r;
   endfunction

   function automatic req_type tick_beat();
      req_type r;
      r = req_type'($bits(req_type)'({$urandom, $urandom}));
      r.cmd = CMD_TICK;
      return r;
   endfunction

   function automatic req_type random_beat();
      req_type r;
      logic [2:0] cat;
      cat = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      r = offer(cat,
                ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'(cat * 16 + $urandom_range(0, 11)),
                ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 3)),
                ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 3)),
                1'($urandom));
      if ($urandom_range(0, 4) == 0) r = tick_beat();
      return r;
   endfunction

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // accept, demote on source, demote on ident, accept without ident
      push_beat(offer(3'd0, 16'h0010, 16'd1, 16'd7, 1'b1));
      push_beat(offer(3'd0, 16'h0010, 16'd2, 16'd7, 1'b1));
      push_beat(offer(3'd0, 16'h0011, 16'd1, 16'd8, 1'b1));
      push_beat(offer(3'd0, 16'h0012, 16'd1, 16'd9, 1'b0));
      // run the watchdogs out, position shifts its level
      repeat (6) push_beat(tick_beat());
      push_beat(offer(3'd0, 16'h0010, 16'd2, 16'd7, 1'b1));
      push_beat(offer(3'd0, 16'h0011, 16'd1, 16'd7, 1'b1));
      // categories past the last one, then all-ones and all-zero ids in valid ones
      push_beat(offer(3'd5, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
      push_beat(offer(3'd7, 16'h0000, 16'h0000, 16'h0000, 1'b0));
      push_beat(offer(3'd6, 16'h1234, 16'h0001, 16'h0001, 1'b1));
      push_beat(offer(3'd4, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
      push_beat(offer(3'd4, 16'h0000, 16'h0000, 16'h0000, 1'b1));
      push_beat(offer(3'd1, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b1));
      push_beat(offer(3'd2, 16'h0000, 16'hFFFF, 16'h0000, 1'b0));
      drain();

      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin
               write_reg(CSR_GPS_TIMEOUT, 8'd1);
               write_reg(CSR_SAT_TIMEOUT, 8'd1);
               write_reg(CSR_FAILOVER_MASK, 8'd31);
            end
            1: begin
               write_reg(CSR_GPS_TIMEOUT, 8'd255);
               write_reg(CSR_SAT_TIMEOUT, 8'd255);
               write_reg(CSR_FAILOVER_MASK, 8'd0);
            end
            2: begin
               write_reg(CSR_GPS_TIMEOUT, 8'd3);
               write_reg(CSR_SAT_TIMEOUT, 8'd200);
               write_reg(CSR_FAILOVER_MASK, 8'd21);
            end
            3: begin
               write_reg(CSR_GPS_TIMEOUT, 8'd2);
               write_reg(CSR_SAT_TIMEOUT, 8'd1);
               write_reg(CSR_FAILOVER_MASK, 8'd10);
            end
            default: begin
               write_reg(CSR_GPS_TIMEOUT, 8'd4);
               write_reg(CSR_SAT_TIMEOUT, 8'd4);
               write_reg(CSR_FAILOVER_MASK, 8'd31);
               calm = 1'b1;
            end
         endcase
         // drive levels into saturation
         if (phase == 0) repeat (270) push_beat(tick_beat());
         for (int n = 0; n < 216; n++) begin
            if (phase == 1 && n == 108) drain();
            push_beat(random_beat());
            maybe_gap();
         end
         drain();
      end

      if (fail_count == 0) $display("source_priority_failover_arbiter test passed");
      else $display("source_priority_failover_arbiter test failed");
      $finish;
   end

endmodule

### sim.f
+incdir+sv
sv/spfa_pkg.sv
sv/spfa_ram.sv
sv/spfa_front.sv
sv/spfa_back.sv
sv/source_priority_failover_arbiter.sv
test/source_priority_failover_arbiter_checker.sv
test/tb_source_priority_failover_arbiter.sv
